### src/kts_pkg.sv
// shared types, constants and helper functions for the keyword token scanner
// used by kts_scan, kts_out_queue and keyword_token_scanner_top; no dependencies
`default_nettype none

package kts_pkg;

    // width of the running byte position counter
    localparam int POSITION_BITS = 16;
    localparam int LEN_BITS      = 16;
    localparam int START_BITS    = 16;
    localparam int CH_BITS       = 8;

    // keyword table
    localparam int NUM_KEYWORDS = 9;
    localparam int KW_MAX_LEN   = 8;
    localparam int KW_IDX_BITS  = 4;

    // result queue depth
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = QPTR_BITS + 1;

    // stream widths
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 48;
    localparam int OUT_TUSER_BITS = 3;

    typedef enum logic [2:0] {
        KIND_NUMBER   = 3'd0,
        KIND_KEYWORD  = 3'd1,
        KIND_IDENT    = 3'd2,
        KIND_OPERATOR = 3'd3,
        KIND_DELIM    = 3'd4,
        KIND_UNKNOWN  = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_NUMBER = 3'b010,
        MODE_WORD   = 3'b100
    } t_mode;

    typedef logic [NUM_KEYWORDS-1:0] t_match;

    // one result beat
    typedef struct packed {
        t_kind                  kind;
        logic [KW_IDX_BITS-1:0] kw_index;
        logic [CH_BITS-1:0]     symbol;
        logic [START_BITS-1:0]  start;
        logic [LEN_BITS-1:0]    len;
        logic                   last;
    } t_token;

    // up to two results pushed per item
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    // keyword text, zero padded
    localparam logic [CH_BITS-1:0] KW_TEXT [NUM_KEYWORDS][KW_MAX_LEN] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "a", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
        4'd3, 4'd5, 4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd4, 4'd4
    };

    // low bits of a position, zero extended when the counter is narrow
    function automatic logic [START_BITS-1:0] to_start(input logic [POSITION_BITS-1:0] p);
        logic [POSITION_BITS+START_BITS-1:0] ext;
        ext = {{START_BITS{1'b0}}, p};
        return ext[START_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

### src/kts_scan.sv
// input register, scan state and per-byte token logic of the keyword token scanner
// depends on kts_pkg
`default_nettype none

module kts_scan (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [kts_pkg::CH_BITS-1:0]     i_ch,
    input  wire logic                            i_eol,
    input  wire logic                            i_room,
    output kts_pkg::t_push                       o_push
);
    import kts_pkg::*;

    localparam t_match MATCH_ONES = '1;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    // input register
    logic                     r_in_valid;
    logic [CH_BITS-1:0]       r_ch;
    logic                     r_eol;

    // scan state
    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [LEN_BITS-1:0]      r_count, n_count;
    t_match                   r_match, n_match;

    logic   fire;
    logic   is_dig, is_head, is_space, is_op, is_delim;
    logic   flush_a, flush_c, sym_valid, have2;
    t_mode  mode1;
    t_match match1;
    logic [LEN_BITS-1:0] count1;
    t_token tok_a, tok_b, tok_c, second;

    // clear match bits of keywords that differ at this offset
    function automatic t_match narrow(input t_match m, input logic [LEN_BITS-1:0] cnt,
                                      input logic [CH_BITS-1:0] c);
        t_match r;
        r = m;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (!(cnt < LEN_BITS'(KW_LEN[k]) && KW_TEXT[k][cnt[2:0]] == c)) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] v);
        return (v == LEN_MAX) ? v : v + 1'b1;
    endfunction

    // pending number or word as a token
    function automatic t_token pending(input t_mode m, input t_match mt,
                                       input logic [LEN_BITS-1:0] cnt,
                                       input logic [POSITION_BITS-1:0] st);
        t_token t;
        t.kind     = (m == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
        t.kw_index = '0;
        t.symbol   = '0;
        t.start    = to_start(st);
        t.len      = cnt;
        t.last     = 1'b0;
        if (m == MODE_WORD) begin
            for (int j = 0; j < NUM_KEYWORDS; j++) begin
                if (mt[j] && cnt == LEN_BITS'(KW_LEN[j])) begin
                    t.kind     = KIND_KEYWORD;
                    t.kw_index = KW_IDX_BITS'(j);
                end
            end
        end
        return t;
    endfunction

    assign fire    = r_in_valid && i_room;
    assign o_ready = !r_in_valid || i_room;

    // byte classes
    always_comb begin
        is_dig   = (r_ch >= "0") && (r_ch <= "9");
        is_head  = ((r_ch >= "a") && (r_ch <= "z")) || ((r_ch >= "A") && (r_ch <= "Z")) ||
                   (r_ch == "_");
        is_space = (r_ch == " ") || ((r_ch >= 8'd9) && (r_ch <= 8'd13));
        is_op    = (r_ch == "+") || (r_ch == "-") || (r_ch == "*") || (r_ch == "/") ||
                   (r_ch == "=") || (r_ch == "<") || (r_ch == ">") || (r_ch == "!");
        is_delim = (r_ch == ";") || (r_ch == "(") || (r_ch == ")") || (r_ch == "{") ||
                   (r_ch == "}");
    end

    // next state and results for the registered byte
    always_comb begin
        flush_a = ((r_mode == MODE_NUMBER) && !is_dig) ||
                  ((r_mode == MODE_WORD) && !(is_head || is_dig));
        tok_a   = pending(r_mode, r_match, r_count, r_start);

        mode1  = flush_a ? MODE_IDLE : r_mode;
        match1 = flush_a ? MATCH_ONES : r_match;
        count1 = flush_a ? '0 : r_count;

        n_mode    = mode1;
        n_match   = match1;
        n_count   = count1;
        n_start   = r_start;
        sym_valid = 1'b0;

        if (mode1 == MODE_NUMBER) begin
            n_count = sat_inc(count1);
        end else if (mode1 == MODE_WORD) begin
            n_match = narrow(match1, count1, r_ch);
            n_count = sat_inc(count1);
        end else if (is_space) begin
            n_count = count1;
        end else if (is_dig) begin
            n_mode  = MODE_NUMBER;
            n_start = r_pos;
            n_count = LEN_BITS'(1);
        end else if (is_head) begin
            n_mode  = MODE_WORD;
            n_start = r_pos;
            n_match = narrow(MATCH_ONES, '0, r_ch);
            n_count = LEN_BITS'(1);
        end else begin
            sym_valid = 1'b1;
        end

        // one-byte symbol token
        tok_b.kind     = is_op ? KIND_OPERATOR : (is_delim ? KIND_DELIM : KIND_UNKNOWN);
        tok_b.kw_index = '0;
        tok_b.symbol   = r_ch;
        tok_b.start    = to_start(r_pos);
        tok_b.len      = LEN_BITS'(1);
        tok_b.last     = 1'b0;

        n_pos = r_pos + 1'b1;

        // end of line closes whatever is pending
        flush_c = r_eol && (n_mode != MODE_IDLE);
        tok_c   = pending(n_mode, n_match, n_count, n_start);
        if (r_eol) begin
            n_mode  = MODE_IDLE;
            n_count = '0;
            n_match = MATCH_ONES;
            n_pos   = '0;
            n_start = '0;
        end

        second = sym_valid ? tok_b : tok_c;
        have2  = sym_valid || flush_c;

        o_push.cnt       = fire ? (2'(flush_a) + 2'(have2)) : 2'd0;
        o_push.tok0      = flush_a ? tok_a : second;
        o_push.tok0.last = !(flush_a && have2);
        o_push.tok1      = second;
        o_push.tok1.last = 1'b1;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ch  <= i_ch;
            r_eol <= i_eol;
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_count <= '0;
            r_match <= MATCH_ONES;
        end else if (fire) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_count <= n_count;
            r_match <= n_match;
        end
    end

endmodule

`default_nettype wire

### src/kts_out_queue.sv
// small result queue of the keyword token scanner, takes up to two beats per cycle
// depends on kts_pkg
`default_nettype none

module kts_out_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire kts_pkg::t_push i_push,
    output logic                o_room,
    output logic                o_valid,
    input  wire logic           i_ready,
    output kts_pkg::t_token     o_token
);
    import kts_pkg::*;

    t_token                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_BITS-1:0]  r_count;
    logic                  pop;
    logic [QPTR_BITS-1:0]  wr_ptr1;

    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    // room for two more beats
    assign o_room  = (r_count <= QCNT_BITS'(QUEUE_DEPTH - 2));
    assign wr_ptr1 = r_wr_ptr + 1'b1;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.tok1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_BITS'(i_push.cnt);
            r_rd_ptr <= r_rd_ptr + QPTR_BITS'(pop);
            r_count  <= r_count + QCNT_BITS'(i_push.cnt) - QCNT_BITS'(pop);
        end
    end

endmodule

`default_nettype wire

### src/keyword_token_scanner_top.sv
// Keyword token scanner: byte stream in, token stream out.
// Input beats carry one source byte in s_axis_tdata and the end-of-line mark in
// s_axis_tlast. Each byte may produce zero, one or two output beats (a pending
// number or word closed by the byte, then the byte's own symbol token, or the
// token closed at end of line); m_axis_tlast marks the last beat of a byte.
// m_axis_tuser carries the token kind, m_axis_tdata the keyword index, symbol,
// start position and length.
// A byte is held in the input register, then the token logic writes its result beats
// into the result queue, which drives the output.
// Throughput: one byte per cycle while the queue holds at most two beats; a long run
// of bytes that give two results is held back by the single output port, which
// sends their beats one at a time.
// Reset (synchronous, active low) empties the queue and the input register,
// sets the scan mode idle, position and length to zero and all keyword matches.
// When the receiver stalls the four-entry result queue fills and s_axis_tready
// drops; no beat is dropped or repeated.
// depends on kts_pkg, kts_scan, kts_out_queue
`default_nettype none

module keyword_token_scanner_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [7:0] ch
    input  wire logic [kts_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
    input  wire logic                                  s_axis_tlast,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [3:0] keyword_index, [11:4] symbol, [27:12] start_position,
    // [43:28] token_length, [47:44] zero
    output logic [kts_pkg::OUT_TDATA_BITS-1:0]         m_axis_tdata,
    // [2:0] kind
    output logic [kts_pkg::OUT_TUSER_BITS-1:0]         m_axis_tuser,
    output logic                                       m_axis_tlast
);
    import kts_pkg::*;

    t_push  push;
    logic   room;
    t_token tok;

    // per-byte token logic
    kts_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_ch    (s_axis_tdata[CH_BITS-1:0]),
        .i_eol   (s_axis_tlast),
        .i_room  (room),
        .o_push  (push)
    );

    // result queue
    kts_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_token (tok)
    );

    // output beat packing
    assign m_axis_tdata = {4'b0, tok.len, tok.start, tok.symbol, tok.kw_index};
    assign m_axis_tuser = tok.kind;
    assign m_axis_tlast = tok.last;

endmodule

`default_nettype wire

### bench/tb_top.sv
// self-checking bench for keyword_token_scanner_top: byte beats in, token beats out
// every accepted byte runs through a behavioral scanner, tokens are checked in order
// depends on kts_pkg and keyword_token_scanner_top
module tb_top;
    import kts_pkg::*;

    localparam int LIMIT_CYCLES   = 2_000_000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_BYTES   = 620;
    localparam int LONG_RUN       = 65537;
    localparam int MODEL          = -1;
    localparam int REPORT_MAX     = 10;
    localparam logic [15:0] LEN_SAT = 16'hFFFF;

    // one token as it leaves the block
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  kw_idx;
        logic [7:0]  symbol;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } t_exp_token;

    // one directed step: fixed_n typed tokens, or MODEL to use the scanner
    typedef struct {
        logic [7:0] ch;
        logic       eol;
        int         fixed_n;
        t_exp_token t0;
        t_exp_token t1;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] ch
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // [3:0] idx, [11:4] sym, [27:12] start, [43:28] len
    logic [2:0]  m_axis_tuser;         // [2:0] kind
    logic        m_axis_tlast;

    // scanner state mirrored for prediction
    t_mode       scan_mode = MODE_IDLE;
    logic [15:0] line_pos  = '0;
    logic [15:0] tok_start = '0;
    logic [15:0] tok_len   = '0;
    logic [8:0]  kw_live   = '1;
    t_exp_token  step_toks [$];
    t_exp_token  token_q [$];

    string kw_word [9] = '{"int", "float", "if", "else", "while", "for", "return",
                           "void", "main"};

    bit steady      = 1'b0;
    bit rx_hold_req = 1'b0;
    int faults      = 0;
    int cycles      = 0;

    keyword_token_scanner_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // byte classes
    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic t_exp_token tk(t_kind kind, int idx, logic [7:0] sym, int start,
                                      int len, bit last);
        t_exp_token t;
        t.kind   = kind;
        t.kw_idx = 4'(idx);
        t.symbol = sym;
        t.start  = 16'(start);
        t.len    = 16'(len);
        t.last   = last;
        return t;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] word_char(bit head);
        int r;
        r = $urandom_range(0, head ? 52 : 62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r == 52)
            return "_";
        return 8'("0" + r - 53);
    endfunction

    // drop every keyword whose next letter differs
    task automatic narrow_keywords(logic [7:0] c);
        for (int k = 0; k < 9; k++) begin
            if (!(tok_len < kw_word[k].len() && kw_word[k][tok_len] == c))
                kw_live[k] = 1'b0;
        end
    endtask

    // emit the pending number or word and go idle
    task automatic close_token();
        t_exp_token t;
        t       = '0;
        t.start = tok_start;
        t.len   = tok_len;
        if (scan_mode == MODE_NUMBER) begin
            t.kind = KIND_NUMBER;
            step_toks.push_back(t);
        end else if (scan_mode == MODE_WORD) begin
            t.kind = KIND_IDENT;
            for (int j = 0; j < 9; j++) begin
                if (kw_live[j] && kw_word[j].len() == tok_len) begin
                    t.kind   = KIND_KEYWORD;
                    t.kw_idx = 4'(j);
                end
            end
            step_toks.push_back(t);
        end
        scan_mode = MODE_IDLE;
        tok_len   = '0;
        kw_live   = '1;
    endtask

    // tokens caused by one byte, left in step_toks
    task automatic scan_byte(logic [7:0] c, logic eol);
        t_exp_token t;
        step_toks.delete();
        if ((scan_mode == MODE_NUMBER && !is_digit(c)) ||
            (scan_mode == MODE_WORD && !(is_alpha(c) || is_digit(c))))
            close_token();

        if (scan_mode != MODE_IDLE) begin
            if (scan_mode == MODE_WORD)
                narrow_keywords(c);
            if (tok_len != LEN_SAT)
                tok_len++;
        end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            // white space only separates tokens
        end else if (is_digit(c)) begin
            scan_mode = MODE_NUMBER;
            tok_start = line_pos;
            tok_len   = 16'd1;
        end else if (is_alpha(c)) begin
            scan_mode = MODE_WORD;
            tok_start = line_pos;
            kw_live   = '1;
            tok_len   = '0;
            narrow_keywords(c);
            tok_len   = 16'd1;
        end else begin
            t        = '0;
            t.symbol = c;
            t.start  = line_pos;
            t.len    = 16'd1;
            case (c)
                "+", "-", "*", "/", "=", "<", ">", "!": t.kind = KIND_OPERATOR;
                ";", "(", ")", "{", "}":                t.kind = KIND_DELIM;
                default:                                t.kind = KIND_UNKNOWN;
            endcase
            step_toks.push_back(t);
        end

        line_pos++;
        if (eol) begin
            close_token();
            line_pos  = '0;
            tok_start = '0;
        end
        if (step_toks.size() > 0)
            step_toks[step_toks.size() - 1].last = 1'b1;
    endtask

    // offer one byte beat and wait until it is taken
    task automatic send_byte(logic [7:0] c, logic eol);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eol;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic feed(logic [7:0] c, logic eol);
        send_byte(c, eol);
        scan_byte(c, eol);
        foreach (step_toks[j])
            token_q.push_back(step_toks[j]);
    endtask

    // stop offering until every pending token has come out
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (token_q.size() != 0);
    endtask

    task automatic note_fault(string msg);
        faults++;
        if (faults <= REPORT_MAX)
            $display("[%0t] %s", $time, msg);
    endtask

    // receiver: random stalls, one long hold on request
    initial begin
        int run;
        int gap;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                run = steady ? 1 : $urandom_range(1, 12);
                m_axis_tready <= 1'b1;
                repeat (run) @(posedge i_clk);
                gap = steady ? 0 : pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // token checker
    always @(posedge i_clk) begin
        t_exp_token want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (token_q.size() == 0) begin
                note_fault($sformatf("unexpected token beat: tuser %0d tdata %h tlast %b",
                                     m_axis_tuser, m_axis_tdata, m_axis_tlast));
            end else begin
                want = token_q.pop_front();
                if (m_axis_tuser !== want.kind || m_axis_tdata[3:0] !== want.kw_idx ||
                    m_axis_tdata[11:4] !== want.symbol ||
                    m_axis_tdata[27:12] !== want.start ||
                    m_axis_tdata[43:28] !== want.len || m_axis_tdata[47:44] !== 4'd0 ||
                    m_axis_tlast !== want.last)
                    note_fault($sformatf({"token mismatch: expected kind %0d idx %0d sym %h",
                        " start %0d len %0d last %b; got kind %0d idx %0d sym %h start %0d",
                        " len %0d last %b pad %h"},
                        want.kind, want.kw_idx, want.symbol, want.start, want.len,
                        want.last, m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[11:4],
                        m_axis_tdata[27:12], m_axis_tdata[43:28], m_axis_tlast,
                        m_axis_tdata[47:44]));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_dir_row   rows [$];
        t_exp_token none;
        logic [7:0] line_q [$];
        string      ops;
        string      delims;
        string      w;
        int         fed;
        int         lines;
        int         cut;
        int         r;

        none   = '0;
        ops    = "+-*/=<>!";
        delims = ";(){}";
        fed    = 0;
        lines  = 0;

        // directed steps, positions count from the start of each line
        rows.push_back(t_dir_row'{"+",   1'b0, 1, tk(KIND_OPERATOR, 0, "+", 0, 1, 1), none});
        rows.push_back(t_dir_row'{8'hFF, 1'b0, 1, tk(KIND_UNKNOWN, 0, 8'hFF, 1, 1, 1), none});
        rows.push_back(t_dir_row'{8'h00, 1'b0, 1, tk(KIND_UNKNOWN, 0, 8'h00, 2, 1, 1), none});
        rows.push_back(t_dir_row'{"i",   1'b0, 0, none, none});
        rows.push_back(t_dir_row'{"n",   1'b0, 0, none, none});
        rows.push_back(t_dir_row'{"t",   1'b0, 0, none, none});
        rows.push_back(t_dir_row'{";",   1'b0, 2, tk(KIND_KEYWORD, 0, 8'h00, 3, 3, 0),
                                  tk(KIND_DELIM, 0, ";", 6, 1, 1)});
        rows.push_back(t_dir_row'{8'h09, 1'b0, 0, none, none});
        rows.push_back(t_dir_row'{"7",   1'b0, MODEL, none, none});
        rows.push_back(t_dir_row'{"0",   1'b0, MODEL, none, none});
        rows.push_back(t_dir_row'{"x",   1'b0, MODEL, none, none});
        rows.push_back(t_dir_row'{"_",   1'b0, MODEL, none, none});
        rows.push_back(t_dir_row'{" ",   1'b0, MODEL, none, none});
        rows.push_back(t_dir_row'{"(",   1'b0, MODEL, none, none});
        rows.push_back(t_dir_row'{"m",   1'b0, 0, none, none});
        rows.push_back(t_dir_row'{"a",   1'b0, 0, none, none});
        rows.push_back(t_dir_row'{"i",   1'b0, 0, none, none});
        rows.push_back(t_dir_row'{"n",   1'b1, 1, tk(KIND_KEYWORD, 8, 8'h00, 14, 4, 1), none});
        rows.push_back(t_dir_row'{"9",   1'b1, 1, tk(KIND_NUMBER, 0, 8'h00, 0, 1, 1), none});
        rows.push_back(t_dir_row'{"-",   1'b1, 1, tk(KIND_OPERATOR, 0, "-", 0, 1, 1), none});
        rows.push_back(t_dir_row'{"A",   1'b0, MODEL, none, none});
        rows.push_back(t_dir_row'{"9",   1'b0, MODEL, none, none});
        rows.push_back(t_dir_row'{"}",   1'b1, MODEL, none, none});
        rows.push_back(t_dir_row'{8'h0D, 1'b1, 0, none, none});
        rows.push_back(t_dir_row'{8'h7F, 1'b0, MODEL, none, none});
        rows.push_back(t_dir_row'{8'h80, 1'b1, MODEL, none, none});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            send_byte(rows[i].ch, rows[i].eol);
            scan_byte(rows[i].ch, rows[i].eol);
            if (rows[i].fixed_n == MODEL) begin
                foreach (step_toks[j])
                    token_q.push_back(step_toks[j]);
            end else begin
                if (rows[i].fixed_n > 0)
                    token_q.push_back(rows[i].t0);
                if (rows[i].fixed_n > 1)
                    token_q.push_back(rows[i].t1);
            end
        end
        wait_idle();

        // one word past the length limit, the operator after it shows the position wrap
        steady = 1'b1;
        repeat (LONG_RUN) feed("z", 1'b0);
        feed("+", 1'b1);
        wait_idle();
        steady = 1'b0;

        // random lines, mostly well-formed token text
        while (fed < RANDOM_BYTES) begin
            line_q.delete();
            if ($urandom_range(0, 99) < 12) begin
                repeat ($urandom_range(1, 10))
                    line_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: begin
                            // keyword, sometimes cut short or with a tail
                            w   = kw_word[$urandom_range(0, 8)];
                            r   = $urandom_range(0, 9);
                            cut = (r == 0) ? w.len() - 1 : w.len();
                            for (int i = 0; i < cut; i++)
                                line_q.push_back(w[i]);
                            if (r == 1)
                                line_q.push_back(word_char(1'b0));
                        end
                        3, 4: begin
                            line_q.push_back(word_char(1'b1));
                            repeat ($urandom_range(0, 7))
                                line_q.push_back(word_char(1'b0));
                        end
                        5, 6: begin
                            repeat ($urandom_range(1, 6))
                                line_q.push_back(8'("0" + $urandom_range(0, 9)));
                        end
                        7:       line_q.push_back(ops[$urandom_range(0, 7)]);
                        8:       line_q.push_back(delims[$urandom_range(0, 4)]);
                        default: line_q.push_back(8'($urandom_range(0, 255)));
                    endcase
                    // optional white space between tokens
                    if ($urandom_range(0, 1)) begin
                        r = $urandom_range(8, 13);
                        line_q.push_back((r == 8) ? 8'(" ") : 8'(r));
                    end
                end
            end
            foreach (line_q[i])
                feed(line_q[i], i == line_q.size() - 1);
            fed += line_q.size();
            lines++;
            if (lines == 8)
                rx_hold_req = 1'b1;
            if (lines == 30 || $urandom_range(0, 99) < 5)
                wait_idle();
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (faults == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
